// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and helper functions shared by the screen box projector.
package pps_pkg;

   // fixed-point formats
   localparam int WORLD_W    = 24;          // world coordinates, Q16.8
   localparam int WORLD_FRAC = 8;
   localparam int COEF_W     = 32;          // matrix coefficients, Q16.16
   localparam int HEIGHT_UNITS = 72;        // figure height in world units
   localparam logic signed [20:0] HEIGHT_RAW = 21'(HEIGHT_UNITS * 256);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int MAT_REGS   = 6;
   localparam int SCR_REG_W  = 14;
   localparam logic [SCR_REG_W-1:0] SCR_W_RESET = 14'd1920;
   localparam logic [SCR_REG_W-1:0] SCR_H_RESET = 14'd1080;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0_AB, CSR_ROW0_CD, CSR_ROW1_AB, CSR_ROW1_CD,
      CSR_ROW3_AB, CSR_ROW3_CD, CSR_SCREEN_WIDTH, CSR_SCREEN_HEIGHT
   } csr_index_type;

   // datapath widths
   localparam int ROWS    = 3;              // x, y and w rows
   localparam int ROW_W   = 2;              // index of the w row
   localparam int POINTS  = 2;              // base and top
   localparam int LANES   = 4;              // base x, base y, top x, top y
   localparam int DOT_W   = 58;             // row dot product, 24 fraction bits
   localparam int MAG_W   = 57;             // |dot| and divisor
   localparam int FRAC    = 20;             // fraction bits of the ratio
   localparam int DIV_STEPS = 2 * FRAC;
   localparam int DIV_LAT = DIV_STEPS + 1;
   localparam int QW      = 2 * FRAC + 1;   // ratio incl. the saturated value
   localparam int HALF_W  = SCR_REG_W + 3;  // half screen size in Q.4
   localparam int OFF_W   = HALF_W + QW - FRAC;
   localparam int SCR_W   = OFF_W + 2;      // screen coordinate, Q.4
   localparam int D5_CHUNK  = 6;
   localparam int D5_STAGES = 7;
   localparam int V_W     = D5_STAGES * D5_CHUNK;
   localparam int BOX_W   = V_W;            // height and x sum
   localparam int LEFT_W  = BOX_W + 2;
   localparam int LAT     = 5 + DIV_LAT + 13;

   localparam int W_MIN_RAW = 16777;        // w below 0.001
   localparam int MIN_H_Q4  = 128;          // 8 pixels

   localparam int OUT_S_W = 20;
   localparam int OUT_U_W = 19;
   localparam logic signed [LEFT_W-1:0] SAT_S_MAX = LEFT_W'(524287);
   localparam logic signed [LEFT_W-1:0] SAT_S_MIN = -LEFT_W'(524288);
   localparam logic [V_W-1:0] SAT_U_MAX = V_W'(524287);

   typedef enum logic [1:0] {
      RC_OK, RC_BASE_BEHIND, RC_TOP_BEHIND, RC_TOO_SMALL
   } rej_code_type;

   typedef struct packed {
      logic signed [WORLD_W-1:0] world_x;
      logic signed [WORLD_W-1:0] world_y;
      logic signed [WORLD_W-1:0] world_z;
   } req_type;

   typedef struct packed {
      logic                        box_valid;
      logic [1:0]                  reject_code;
      logic signed [OUT_S_W-1:0]   box_left;
      logic signed [OUT_S_W-1:0]   box_top;
      logic [OUT_U_W-1:0]          box_width;
      logic [OUT_U_W-1:0]          box_height;
   } rsp_type;

   typedef struct packed {
      logic [POINTS-1:0] bad;
      logic [LANES-1:0]  neg;
   } side_type;

   typedef struct packed {
      rej_code_type              code;
      logic signed [BOX_W-1:0]   sumx;
      logic signed [SCR_W-1:0]   hy;
      logic signed [BOX_W-1:0]   h;
   } post_type;

   // centre +/- offset; sub flips the direction (screen y grows downwards)
   function automatic logic signed [SCR_W-1:0] screen_pos(
      input logic [HALF_W-1:0] half,
      input logic [OFF_W-1:0]  off,
      input logic              neg,
      input logic              sub
   );
      logic signed [SCR_W-1:0] o;
      o = signed'(SCR_W'(off));
      if (neg ^ sub) begin
         o = -o;
      end
      return signed'(SCR_W'(half)) + o;
   endfunction

   // six bits of a long division by five: returns {quotient bits, remainder}
   function automatic logic [D5_CHUNK+2:0] div5_chunk(
      input logic [2:0]          rem,
      input logic [D5_CHUNK-1:0] bits
   );
      logic [3:0]          t;
      logic [2:0]          r;
      logic [D5_CHUNK-1:0] q;
      r = rem;
      q = '0;
      for (int i = D5_CHUNK - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= 4'd5) begin
            t = t - 4'd5;
            q[i] = 1'b1;
         end
         r = t[2:0];
      end
      return {q, r};
   endfunction

   function automatic logic signed [OUT_S_W-1:0] sat_s(input logic signed [LEFT_W-1:0] v);
      if (v > SAT_S_MAX) begin
         return SAT_S_MAX[OUT_S_W-1:0];
      end else if (v < SAT_S_MIN) begin
         return SAT_S_MIN[OUT_S_W-1:0];
      end
      return v[OUT_S_W-1:0];
   endfunction

   function automatic logic [OUT_U_W-1:0] sat_u(input logic [V_W-1:0] v);
      if (v > SAT_U_MAX) begin
         return SAT_U_MAX[OUT_U_W-1:0];
      end
      return v[OUT_U_W-1:0];
   endfunction

endpackage

// ===== hdl/pps_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: |row| / w with 20 fraction bits, saturating.
module pps_div (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [pps_pkg::MAG_W-1:0] num,
   input  logic [pps_pkg::MAG_W-1:0] den,
   output logic [pps_pkg::QW-1:0]    quot
);
   import pps_pkg::*;

   logic [MAG_W-1:0]     rem_ff [0:DIV_STEPS];
   logic [MAG_W-1:0]     den_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] sh_ff  [0:DIV_STEPS];   // numerator bits out, quotient bits in
   logic                 sat_ff [0:DIV_STEPS];

   // integer part of 2^20 or more saturates; otherwise num >> 20 is below den
   always_ff @(posedge clock) begin
      if (enable) begin
         sat_ff[0] <= {{FRAC{1'b0}}, num} >= {den, {FRAC{1'b0}}};
         rem_ff[0] <= num >> FRAC;
         sh_ff[0]  <= {num[FRAC-1:0], {FRAC{1'b0}}};
         den_ff[0] <= den;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [MAG_W:0]   t;
      logic             ge;
      logic [MAG_W:0]   diff;

      always_comb begin
         t    = {rem_ff[k-1], sh_ff[k-1][DIV_STEPS-1]};
         ge   = t >= {1'b0, den_ff[k-1]};
         diff = t - {1'b0, den_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
            sh_ff[k]  <= {sh_ff[k-1][DIV_STEPS-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign quot = sat_ff[DIV_STEPS] ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, sh_ff[DIV_STEPS]};

endmodule

// ===== hdl/project_point_to_screen_box_top.sv =====
`timescale 1ns / 1ps
// Top level of the screen box projector: matrix rows, dividers, box assembly.
//
//  channel | ports                            | payload
//  --------+----------------------------------+------------------------------
//  request | req_valid / req_ready / req_data | world x, y, z (Q16.8)
//  result  | rsp_valid / rsp_ready / rsp_data | box valid, code, box (Q.4)
//  config  | csr_we / csr_index / csr_wdata   | matrix rows, screen size
//
// One request per cycle while the result side does not stall; the 41-stage
// ratio divider (a set-up stage, then one quotient bit a stage) makes up most
// of the pipeline.
// Synchronous reset clears the pipeline valids and loads the default registers.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module project_point_to_screen_box_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pps_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pps_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [pps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pps_pkg::*;

   logic [CSR_DATA_W-1:0] mat_ff [0:MAT_REGS-1];
   logic [SCR_REG_W-1:0]  scr_w_ff;
   logic [SCR_REG_W-1:0]  scr_h_ff;
   logic [HALF_W-1:0]     half_w;
   logic [HALF_W-1:0]     half_h;
   logic                  adv;
   logic [LAT-1:0]        vld_ff;

   assign half_w = {scr_w_ff, 3'b000};
   assign half_h = {scr_h_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_REGS; i++) begin
            mat_ff[i] <= '0;
         end
         scr_w_ff <= SCR_W_RESET;
         scr_h_ff <= SCR_H_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH: begin
               scr_w_ff <= csr_wdata[SCR_REG_W-1:0];
            end
            CSR_SCREEN_HEIGHT: begin
               scr_h_ff <= csr_wdata[SCR_REG_W-1:0];
            end
            default: begin
               mat_ff[csr_index] <= csr_wdata;
            end
         endcase
      end
   end

   // whole pipeline moves unless the result register is full and not taken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // stage 1: products
   logic signed [DOT_W-1:0] mx_in [ROWS], my_in [ROWS], mz_in [ROWS], mt_in [ROWS], mh_in [ROWS];
   logic signed [DOT_W-1:0] mx_ff [ROWS], my_ff [ROWS], mz_ff [ROWS], mt_ff [ROWS], mh_ff [ROWS];

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         mx_in[r] = DOT_W'($signed(mat_ff[2*r][COEF_W-1:0]) * req_data.world_x);
         my_in[r] = DOT_W'($signed(mat_ff[2*r][2*COEF_W-1:COEF_W]) * req_data.world_y);
         mz_in[r] = DOT_W'($signed(mat_ff[2*r+1][COEF_W-1:0]) * req_data.world_z);
         mt_in[r] = DOT_W'($signed(mat_ff[2*r+1][2*COEF_W-1:COEF_W])) <<< WORLD_FRAC;
         mh_in[r] = DOT_W'($signed(mat_ff[2*r+1][COEF_W-1:0]) * HEIGHT_RAW);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         mz_ff <= mz_in;
         mt_ff <= mt_in;
         mh_ff <= mh_in;
      end
   end

   // stages 2-4: sums; the top point only adds c2 * height
   logic signed [DOT_W-1:0] s01_ff [ROWS], s23_ff [ROWS], mh2_ff [ROWS];
   logic signed [DOT_W-1:0] base_ff [ROWS], mh3_ff [ROWS];
   logic signed [DOT_W-1:0] dot_ff [POINTS][ROWS];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < ROWS; r++) begin
            s01_ff[r]    <= mx_ff[r] + my_ff[r];
            s23_ff[r]    <= mz_ff[r] + mt_ff[r];
            mh2_ff[r]    <= mh_ff[r];
            base_ff[r]   <= s01_ff[r] + s23_ff[r];
            mh3_ff[r]    <= mh2_ff[r];
            dot_ff[0][r] <= base_ff[r];
            dot_ff[1][r] <= base_ff[r] + mh3_ff[r];
         end
      end
   end

   // stage 5: camera test, magnitudes and signs
   logic [MAG_W-1:0]  num_in [LANES], num_ff [LANES];
   logic [MAG_W-1:0]  den_in [POINTS], den_ff [POINTS];
   logic [LANES-1:0]  neg_in, neg_ff;
   logic [POINTS-1:0] bad_in, bad_ff;

   always_comb begin
      logic signed [DOT_W-1:0] d;
      logic signed [DOT_W-1:0] nd;
      for (int p = 0; p < POINTS; p++) begin
         bad_in[p] = dot_ff[p][ROW_W] <= W_MIN_RAW;
         den_in[p] = dot_ff[p][ROW_W][MAG_W-1:0];
         for (int a = 0; a < 2; a++) begin
            d  = dot_ff[p][a];
            nd = -d;
            neg_in[2*p+a] = d[DOT_W-1];
            num_in[2*p+a] = d[DOT_W-1] ? nd[MAG_W-1:0] : d[MAG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         den_ff <= den_in;
         neg_ff <= neg_in;
         bad_ff <= bad_in;
      end
   end

   // ratio dividers, with flags delayed alongside
   logic [QW-1:0] quot [LANES];
   side_type      side_ff [0:DIV_LAT-1];

   for (genvar l = 0; l < LANES; l++) begin : g_div
      pps_div u_div (
         .clock  (clock),
         .enable (adv),
         .num    (num_ff[l]),
         .den    (den_ff[l >> 1]),
         .quot   (quot[l])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{bad: bad_ff, neg: neg_ff};
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // stage 6: pixel offsets
   logic [OFF_W-1:0] off_in [LANES], off_ff [LANES];
   side_type         side6_ff;

   always_comb begin
      logic [HALF_W+QW-1:0] prod;
      for (int l = 0; l < LANES; l++) begin
         prod      = (l % 2 == 1 ? half_h : half_w) * quot[l];
         off_in[l] = prod[FRAC +: OFF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff   <= off_in;
         side6_ff <= side_ff[DIV_LAT-1];
      end
   end

   // stage 7: screen points
   logic signed [SCR_W-1:0] fx_ff, fy_ff, hx_ff, hy_ff;
   rej_code_type            code7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff <= screen_pos(half_w, off_ff[0], side6_ff.neg[0], 1'b0);
         fy_ff <= screen_pos(half_h, off_ff[1], side6_ff.neg[1], 1'b1);
         hx_ff <= screen_pos(half_w, off_ff[2], side6_ff.neg[2], 1'b0);
         hy_ff <= screen_pos(half_h, off_ff[3], side6_ff.neg[3], 1'b1);
         if (side6_ff.bad[0]) begin
            code7_ff <= RC_BASE_BEHIND;
         end else if (side6_ff.bad[1]) begin
            code7_ff <= RC_TOP_BEHIND;
         end else begin
            code7_ff <= RC_OK;
         end
      end
   end

   // stage 8: height and x sum
   logic signed [BOX_W-1:0] h_in;
   post_type                post8_ff;

   assign h_in = BOX_W'(fy_ff) - BOX_W'(hy_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         post8_ff.h    <= h_in;
         post8_ff.sumx <= BOX_W'(hx_ff) + BOX_W'(fx_ff);
         post8_ff.hy   <= hy_ff;
         post8_ff.code <= (code7_ff == RC_OK && h_in < MIN_H_Q4) ? RC_TOO_SMALL : code7_ff;
      end
   end

   // stage 9 onwards: width = floor(floor(9h/4) / 5), six bits a stage
   logic signed [BOX_W+3:0] h9e;
   logic signed [BOX_W+3:0] h9;
   logic [V_W-1:0]          d5_w_ff   [0:D5_STAGES];
   logic [2:0]              d5_rem_ff [0:D5_STAGES];
   post_type                d5_post_ff [0:D5_STAGES];

   assign h9e = (BOX_W+4)'(post8_ff.h);
   assign h9  = (h9e <<< 3) + h9e;

   always_ff @(posedge clock) begin
      if (adv) begin
         d5_w_ff[0]    <= h9[V_W+1:2];
         d5_rem_ff[0]  <= '0;
         d5_post_ff[0] <= post8_ff;
      end
   end

   for (genvar k = 1; k <= D5_STAGES; k++) begin : g_d5
      logic [D5_CHUNK+2:0] res;

      assign res = div5_chunk(d5_rem_ff[k-1], d5_w_ff[k-1][V_W-1 -: D5_CHUNK]);

      always_ff @(posedge clock) begin
         if (adv) begin
            d5_rem_ff[k]  <= res[2:0];
            d5_w_ff[k]    <= {d5_w_ff[k-1][V_W-D5_CHUNK-1:0], res[D5_CHUNK+2:3]};
            d5_post_ff[k] <= d5_post_ff[k-1];
         end
      end
   end

   // stage 17: left edge, floor of half
   logic signed [LEFT_W-1:0] left_ff;
   logic [V_W-1:0]           w17_ff;
   post_type                 post17_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff   <= (LEFT_W'(d5_post_ff[D5_STAGES].sumx)
                       - LEFT_W'(signed'({1'b0, d5_w_ff[D5_STAGES]}))) >>> 1;
         w17_ff    <= d5_w_ff[D5_STAGES];
         post17_ff <= d5_post_ff[D5_STAGES];
      end
   end

   // stage 18: saturation and result register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data.reject_code <= post17_ff.code;
         if (post17_ff.code == RC_OK) begin
            rsp_data.box_valid  <= 1'b1;
            rsp_data.box_left   <= sat_s(left_ff);
            rsp_data.box_top    <= sat_s(LEFT_W'(post17_ff.hy));
            rsp_data.box_width  <= sat_u(w17_ff);
            rsp_data.box_height <= sat_u(post17_ff.h[V_W-1:0]);
         end else begin
            rsp_data.box_valid  <= 1'b0;
            rsp_data.box_left   <= '0;
            rsp_data.box_top    <= '0;
            rsp_data.box_width  <= '0;
            rsp_data.box_height <= '0;
         end
      end
   end

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("pipeline stalled without a pending result");

   a_valid_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.box_valid == (rsp_data.reject_code == RC_OK)))
      else $error("box_valid disagrees with reject code");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.box_valid |-> rsp_data.box_left == '0 &&
         rsp_data.box_top == '0 && rsp_data.box_width == '0 && rsp_data.box_height == '0)
      else $error("rejected box carries data");

   a_min_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.box_valid |-> rsp_data.box_height >= OUT_U_W'(MIN_H_Q4))
      else $error("accepted box below minimum height");

endmodule

// ===== tb/sv/project_point_to_screen_box_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the screen box projector: random and directed requests.
module project_point_to_screen_box_top_test;
   import pps_pkg::*;

   class box_scoreboard;
      bit [63:0] regs [8];
      rsp_type   boxes_due [$];
      int        errors;

      function new();
         reset_regs();
      endfunction

      function void reset_regs();
         foreach (regs[i]) begin
            regs[i] = '0;
         end
         regs[CSR_SCREEN_WIDTH]  = 64'(SCR_W_RESET);
         regs[CSR_SCREEN_HEIGHT] = 64'(SCR_H_RESET);
      endfunction

      function void set_reg(csr_index_type idx, bit [63:0] val);
         regs[idx] = (idx >= CSR_SCREEN_WIDTH) ? (val & 64'h3FFF) : val;
      endfunction

      function int pending();
         return boxes_due.size();
      endfunction

      // row 0 = screen x, row 1 = screen y, row 2 = w
      function longint row_sum(int row, longint x, longint y, longint z);
         bit [63:0] ab, cd;
         ab = regs[2 * row];
         cd = regs[2 * row + 1];
         return longint'(signed'(ab[31:0])) * x + longint'(signed'(ab[63:32])) * y
              + longint'(signed'(cd[31:0])) * z + longint'(signed'(cd[63:32])) * 256;
      endfunction

      // |v|/w to 20 fraction bits, saturated once the integer part reaches 2^20
      function bit [63:0] ratio(bit [63:0] num, bit [63:0] den);
         bit [63:0] q, r;
         q = num / den;
         r = num % den;
         if (q >= 64'(1) << FRAC) begin
            return 64'(1) << (2 * FRAC);
         end
         for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q[0] = 1'b1;
            end
         end
         return q;
      endfunction

      function longint offset(longint v, longint w, longint half);
         bit [63:0] mag;
         longint    off;
         mag = (v < 0) ? 64'(-v) : 64'(v);
         off = longint'((64'(half) * ratio(mag, 64'(w))) >> FRAC);
         return (v < 0) ? -off : off;
      endfunction

      function bit project(longint x, longint y, longint z, output longint sx,
                           output longint sy);
         longint w, hw, hh;
         w = row_sum(2, x, y, z);
         sx = 0;
         sy = 0;
         if (w <= W_MIN_RAW) begin
            return 1'b0;
         end
         hw = longint'(regs[CSR_SCREEN_WIDTH]) * 8;
         hh = longint'(regs[CSR_SCREEN_HEIGHT]) * 8;
         sx = hw + offset(row_sum(0, x, y, z), w, hw);
         sy = hh - offset(row_sum(1, x, y, z), w, hh);
         return 1'b1;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void note_request(req_type d);
         longint       x, y, z, fx, fy, hx, hy, h, wd, sum, left;
         rej_code_type code;
         rsp_type      e;
         x = longint'(d.world_x);
         y = longint'(d.world_y);
         z = longint'(d.world_z);
         e = '0;
         code = RC_OK;
         if (!project(x, y, z, fx, fy)) begin
            code = RC_BASE_BEHIND;
         end else if (!project(x, y, z + HEIGHT_UNITS * 256, hx, hy)) begin
            code = RC_TOP_BEHIND;
         end else begin
            h = fy - hy;
            if (h < MIN_H_Q4) begin
               code = RC_TOO_SMALL;
            end
         end
         e.reject_code = code;
         if (code == RC_OK) begin
            wd = h * 45 / 100;
            sum = hx + fx - wd;
            left = (sum >= 0) ? sum / 2 : -((-sum + 1) / 2);
            e.box_valid  = 1'b1;
            e.box_left   = 20'(clip(left, -524288, 524287));
            e.box_top    = 20'(clip(hy, -524288, 524287));
            e.box_width  = 19'(clip(wd, 0, 524287));
            e.box_height = 19'(clip(h, 0, 524287));
         end
         boxes_due.push_back(e);
      endfunction

      function void compare(string field, longint e, longint a);
         if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, e, a);
            errors++;
         end
      endfunction

      function void check_box(rsp_type a);
         rsp_type e;
         if (boxes_due.size() == 0) begin
            $display("%0t: unexpected result %h", $time, a);
            errors++;
            return;
         end
         e = boxes_due.pop_front();
         compare("box_valid", e.box_valid, a.box_valid);
         compare("reject_code", e.reject_code, a.reject_code);
         compare("box_left", e.box_left, a.box_left);
         compare("box_top", e.box_top, a.box_top);
         compare("box_width", e.box_width, a.box_width);
         compare("box_height", e.box_height, a.box_height);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   box_scoreboard sb = new();
   bit  no_idle;
   int  hold_len;

   project_point_to_screen_box_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request(req_data);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_box(rsp_data);
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // called at a clock edge; returns at the edge the request is taken
   task automatic send(req_type d);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_regs(bit [63:0] vals [8]);
      csr_index_type r;
      drain();
      repeat (LAT + 10) @(posedge clock);
      r = CSR_ROW0_AB;
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= r;
         csr_wdata <= vals[i];
         sb.set_reg(r, vals[i]);
         @(posedge clock);
         r = r.next();
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type point(longint x, longint y, longint z);
      req_type d;
      d.world_x = 24'(x);
      d.world_y = 24'(y);
      d.world_z = 24'(z);
      return d;
   endfunction

   // mostly figures in front of the camera, some raw noise
   task automatic run_random(int n);
      longint x, y, z, span;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 4) == 0) begin
            send(point($urandom, $urandom, $urandom));
         end else begin
            z = longint'($urandom_range(0, 1024000)) - 512000;
            span = $urandom_range(60 * 256, 5000 * 256);
            x = z + span;
            y = longint'($urandom_range(0, 2 * span)) - span;
            send(point(x, y, z));
         end
      end
   endtask

   function automatic bit [31:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      bit [63:0] cfg [8];
      longint    k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_idle = 1'b0;
      hold_len = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset matrix is all zero: every request is behind the camera
      for (int i = 0; i < 4; i++) begin
         send(point($urandom, $urandom, $urandom));
      end

      // camera looks along x; w = x - z, screen x from y, screen y from z
      cfg[CSR_ROW0_AB] = {32'h0001_0000, 32'h0};
      cfg[CSR_ROW0_CD] = 64'h0;
      cfg[CSR_ROW1_AB] = 64'h0;
      cfg[CSR_ROW1_CD] = {32'h0, 32'h0001_0000};
      cfg[CSR_ROW3_AB] = {32'h0, 32'h0001_0000};
      cfg[CSR_ROW3_CD] = {32'h0, 32'hFFFF_0000};
      cfg[CSR_SCREEN_WIDTH]  = 1920;
      cfg[CSR_SCREEN_HEIGHT] = 1080;
      program_regs(cfg);

      send(point(0, 0, 0));                       // base behind camera
      send(point(100 * 256, 0, 100 * 256));       // base exactly on the camera plane
      send(point(40 * 256, 0, 0));                // head behind camera
      send(point(72 * 256 + 4, 5, 0));            // head just on the limit
      send(point(8000 * 256, 0, 0));              // too small
      send(point(500 * 256, 0, 0));
      send(point(500 * 256, 400 * 256, -300 * 256));
      send(point(300 * 256, -299 * 256, 200 * 256));
      send(point(80 * 256, 79 * 256, -5 * 256));  // very close: large box
      send(point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      send(point(-8388608, -8388608, -8388608));
      send(point(8388607, -8388608, -8388608));
      send(point(8388607, 8388607, -8388608));
      send(point(8388607, 0, 0));
      send(point(-8388608, 0, 8388607));
      send(point(1, -1, -1));

      // result side holds off long enough for the pipeline to fill
      no_idle = 1'b1;
      hold_len = 400;
      for (int i = 0; i < 100; i++) begin
         k = $urandom_range(100, 3000);
         send(point(k * 256, 0, 0));
      end
      drain();
      run_random(80);
      drain();
      run_random(80);

      // scaled view, random screen width
      k = $urandom_range(32768, 131072);
      cfg[CSR_ROW0_AB] = {32'($urandom_range(32768, 131072)), 32'($urandom_range(0, 4096))};
      cfg[CSR_ROW0_CD] = {32'($urandom_range(0, 65536 * 64)), 32'($urandom_range(0, 4096))};
      cfg[CSR_ROW1_AB] = {32'($urandom_range(0, 4096)), 32'($urandom_range(0, 4096))};
      cfg[CSR_ROW1_CD] = {32'($urandom) & 32'h00FF_FFFF, 32'(k)};
      cfg[CSR_ROW3_AB] = {32'($urandom_range(0, 2048)), 32'(k)};
      cfg[CSR_ROW3_CD] = {32'($urandom_range(0, 65536 * 8)), 32'(-k)};
      cfg[CSR_SCREEN_WIDTH]  = $urandom_range(0, 8192);
      cfg[CSR_SCREEN_HEIGHT] = 8192;
      program_regs(cfg);
      run_random(120);

      // extreme coefficients and screen sizes
      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < 6; i++) begin
            cfg[i] = {rand_coef(), rand_coef()};
         end
         cfg[CSR_ROW3_AB][31:0] = 32'h0001_0000;
         cfg[CSR_SCREEN_WIDTH]  = (p == 0) ? 0 : (p == 1) ? 16383 : $urandom;
         cfg[CSR_SCREEN_HEIGHT] = (p == 0) ? 16383 : (p == 1) ? 0 : $urandom;
         program_regs(cfg);
         run_random(40);
      end

      drain();
      repeat (LAT + 20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
